[hw/rtl/pshp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pshp_pkg
// Shared types and constants for the program-counter hotspot profiler.
// ----------------------------------------------------------------------------
package pshp_pkg;

  localparam int TABLE_DEPTH_DEF = 2048;
  localparam int TOP_SIZE_DEF    = 20;
  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  localparam logic [1:0] FUNC_SAMPLE  = 2'd0;
  localparam logic [1:0] FUNC_READ    = 2'd1;
  localparam logic [1:0] FUNC_RESTART = 2'd2;
  localparam logic [1:0] FUNC_UNUSED  = 2'd3;

  typedef enum logic [1:0] {
    OP_SAMPLE,
    OP_READ,
    OP_RESTART,
    OP_NONE
  } op_t;

  typedef enum logic [1:0] {
    STS_HIT  = 2'd0,
    STS_NEW  = 2'd1,
    STS_DROP = 2'd2,
    STS_NONE = 2'd3
  } sts_t;

  typedef struct packed {
    op_t         op;
    logic [63:0] pc;
    logic [4:0]  rank;
  } cmd_t;

  typedef struct packed {
    sts_t        status;
    logic [63:0] addr;
    logic [31:0] count;
    logic [11:0] used;
  } res_t;

endpackage
`default_nettype wire

[hw/rtl/pshp_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pshp_front
// Accepts words, decodes the function code and queues commands for the back.
// ----------------------------------------------------------------------------
module pshp_front #(
  parameter int TOP_SIZE = pshp_pkg::TOP_SIZE_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  output logic               full,
  input  wire logic [1:0]    func,
  input  wire logic [63:0]   pc_value,
  input  wire logic [4:0]    rank_select,
  output logic               cmd_valid,
  output pshp_pkg::cmd_t     cmd,
  input  wire logic          cmd_pop
);
  import pshp_pkg::*;

  cmd_t       q [2];
  logic       wp, rp;
  logic [1:0] cnt;
  cmd_t       dec;
  logic       do_push, do_pop;

  always_comb begin
    dec.pc   = pc_value;
    dec.rank = rank_select;
    case (func)
      FUNC_SAMPLE:  dec.op = OP_SAMPLE;
      FUNC_READ:    dec.op = (32'(rank_select) < TOP_SIZE) ? OP_READ : OP_NONE;
      FUNC_RESTART: dec.op = OP_RESTART;
      default:      dec.op = OP_NONE;
    endcase
  end

  assign full      = (cnt == 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q[rp];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wp] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop)  rp <= ~rp;
      cnt <= cnt + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule
`default_nettype wire

[hw/rtl/pshp_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pshp_back
// Hit table search, top list update and exchange sort, result queue.
// ----------------------------------------------------------------------------
module pshp_back #(
  parameter int TABLE_DEPTH = pshp_pkg::TABLE_DEPTH_DEF,
  parameter int TOP_SIZE    = pshp_pkg::TOP_SIZE_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  input  wire pshp_pkg::cmd_t cmd,
  output logic               cmd_pop,
  output logic               empty,
  input  wire logic          pop,
  output pshp_pkg::res_t     res
);
  import pshp_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int TW = $clog2(TOP_SIZE);
  localparam logic [TW-1:0] LAST = TW'(TOP_SIZE - 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_HSCAN, ST_MISS, ST_LAST, ST_FIND,
    ST_SRD, ST_SCMP, ST_SWR, ST_RANK, ST_DONE
  } state_t;

  state_t         state;
  logic [IW-1:0]  hidx;
  logic [CW-1:0]  n;
  logic [63:0]    pc;
  logic [31:0]    cand_c, last_c, swap_c;
  logic [63:0]    swap_a;
  logic           force_upd;
  sts_t           status;
  logic [63:0]    raddr;
  logic [31:0]    rcnt;
  logic [TW-1:0]  ti, tj;

  // hit table
  logic [63:0]    hm_a [TABLE_DEPTH];
  logic [31:0]    hm_c [TABLE_DEPTH];
  logic [IW-1:0]  hm_raddr, hm_waddr;
  logic [63:0]    hm_rd_a, hm_wa;
  logic [31:0]    hm_rd_c, hm_wc, hm_inc;
  logic           hm_we, hm_match;

  // top list
  logic [63:0]         ta [TOP_SIZE];
  logic [31:0]         tc [TOP_SIZE];
  logic [TOP_SIZE-1:0] tv;
  logic [TW-1:0]       ra_idx, t_widx;
  logic [63:0]         ra_a, rb_a, t_wa;
  logic [31:0]         ra_c, rb_c, t_wc;
  logic                t_we, t_clr;

  // result queue
  res_t       oq [2];
  logic       owp, orp;
  logic [1:0] ocnt;
  logic       o_push;

  assign hm_inc   = (hm_rd_c == CNT_MAX) ? hm_rd_c : hm_rd_c + 32'd1;
  assign hm_match = (hm_rd_a == pc);
  assign cmd_pop  = (state == ST_IDLE) && cmd_valid && (ocnt != 2'd2);
  assign o_push   = (state == ST_DONE);

  always_comb begin
    hm_raddr = (state == ST_HSCAN) ? hidx + IW'(1) : '0;
    hm_we    = 1'b0;
    hm_waddr = hidx;
    hm_wa    = pc;
    hm_wc    = hm_inc;
    if (state == ST_HSCAN && hm_match) begin
      hm_we = 1'b1;
    end else if (state == ST_MISS && n < CW'(TABLE_DEPTH)) begin
      hm_we    = 1'b1;
      hm_waddr = n[IW-1:0];
      hm_wc    = 32'd1;
    end
  end

  always_comb begin
    case (state)
      ST_IDLE:  ra_idx = TW'(cmd.rank);
      ST_HSCAN: ra_idx = LAST;
      ST_MISS:  ra_idx = LAST;
      ST_LAST:  ra_idx = '0;
      ST_FIND:  ra_idx = tj + TW'(1);
      default:  ra_idx = ti;
    endcase
    t_we   = 1'b0;
    t_widx = tj;
    t_wa   = pc;
    t_wc   = cand_c;
    case (state)
      ST_FIND: begin
        if (ra_a == pc) begin
          t_we = 1'b1;
        end else if (tj == LAST && cand_c > last_c) begin
          t_we = 1'b1;
        end
      end
      ST_SCMP: begin
        t_we = (ra_c < rb_c);
        t_wa = ra_a;
        t_wc = ra_c;
      end
      ST_SWR: begin
        t_we   = 1'b1;
        t_widx = ti;
        t_wa   = swap_a;
        t_wc   = swap_c;
      end
      default: t_we = 1'b0;
    endcase
    t_clr = cmd_pop && (cmd.op == OP_RESTART);
  end

  always_ff @(posedge clk) begin
    hm_rd_a <= hm_a[hm_raddr];
    hm_rd_c <= hm_c[hm_raddr];
    if (hm_we) begin
      hm_a[hm_waddr] <= hm_wa;
      hm_c[hm_waddr] <= hm_wc;
    end
  end

  always_ff @(posedge clk) begin
    ra_a <= tv[ra_idx] ? ta[ra_idx] : 64'd0;
    ra_c <= tv[ra_idx] ? tc[ra_idx] : 32'd0;
    rb_a <= tv[tj] ? ta[tj] : 64'd0;
    rb_c <= tv[tj] ? tc[tj] : 32'd0;
    if (t_we) begin
      ta[t_widx] <= t_wa;
      tc[t_widx] <= t_wc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || t_clr) begin
      tv <= '0;
    end else if (t_we) begin
      tv[t_widx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      n     <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd_pop) begin
            pc     <= cmd.pc;
            raddr  <= 64'd0;
            rcnt   <= 32'd0;
            status <= STS_NONE;
            case (cmd.op)
              OP_SAMPLE: begin
                hidx  <= '0;
                state <= (n == '0) ? ST_MISS : ST_HSCAN;
              end
              OP_READ: state <= ST_RANK;
              default: state <= ST_DONE;
            endcase
          end
        end
        ST_HSCAN: begin
          if (hm_match) begin
            status    <= STS_HIT;
            cand_c    <= hm_inc;
            force_upd <= 1'b0;
            state     <= ST_LAST;
          end else if (CW'(hidx) + CW'(1) == n) begin
            state <= ST_MISS;
          end else begin
            hidx <= hidx + IW'(1);
          end
        end
        ST_MISS: begin
          if (n < CW'(TABLE_DEPTH)) begin
            n         <= n + CW'(1);
            status    <= STS_NEW;
            cand_c    <= 32'd1;
            force_upd <= (32'(n) + 32'd1 <= TOP_SIZE);
            state     <= ST_LAST;
          end else begin
            status <= STS_DROP;
            state  <= ST_DONE;
          end
        end
        ST_LAST: begin
          last_c <= ra_c;
          if (force_upd || cand_c > ra_c) begin
            tj    <= '0;
            state <= ST_FIND;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_FIND: begin
          if (ra_a == pc || tj == LAST) begin
            ti    <= '0;
            tj    <= TW'(1);
            state <= ST_SRD;
          end else begin
            tj <= tj + TW'(1);
          end
        end
        ST_SRD: state <= ST_SCMP;
        ST_SCMP, ST_SWR: begin
          if (state == ST_SCMP && ra_c < rb_c) begin
            swap_a <= rb_a;
            swap_c <= rb_c;
            state  <= ST_SWR;
          end else if (tj == LAST) begin
            if (ti == TW'(TOP_SIZE - 2)) begin
              state <= ST_DONE;
            end else begin
              ti    <= ti + TW'(1);
              tj    <= ti + TW'(2);
              state <= ST_SRD;
            end
          end else begin
            tj    <= tj + TW'(1);
            state <= ST_SRD;
          end
        end
        ST_RANK: begin
          raddr <= ra_a;
          rcnt  <= ra_c;
          state <= ST_DONE;
        end
        ST_DONE: state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (o_push) begin
      oq[owp] <= '{status: status, addr: raddr, count: rcnt, used: 12'(n)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owp  <= 1'b0;
      orp  <= 1'b0;
      ocnt <= 2'd0;
    end else begin
      if (o_push)           owp <= ~owp;
      if (pop && !empty)    orp <= ~orp;
      ocnt <= ocnt + 2'(o_push) - 2'(pop && !empty);
    end
  end

  assign empty = (ocnt == 2'd0);
  assign res   = oq[orp];

endmodule
`default_nettype wire

[hw/rtl/pc_sample_hotspot_profiler_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pc_sample_hotspot_profiler_top
// Program-counter sample profiler with a hit table and a sorted top list.
// ----------------------------------------------------------------------------
// One word is worked on at a time. A sample scans the hit table one entry
// per cycle through its single read port; when the top list changes, a
// search of up to TOP_SIZE slots and an exchange sort over
// TOP_SIZE*(TOP_SIZE-1)/2 pairs of slots follow. A two-deep input queue
// and a two-deep result queue let each side stall on its own. No clearing
// pass is needed after reset.
module pc_sample_hotspot_profiler_top #(
  parameter int TABLE_DEPTH = pshp_pkg::TABLE_DEPTH_DEF,
  parameter int TOP_SIZE    = pshp_pkg::TOP_SIZE_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  func,
  input  wire logic [63:0] pc_value,
  input  wire logic [4:0]  rank_select,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       sample_status,
  output logic [63:0]      rank_address,
  output logic [31:0]      rank_count,
  output logic [11:0]      entries_used
);
  import pshp_pkg::*;

  logic cmd_valid, cmd_pop;
  cmd_t cmd;
  res_t res;

  pshp_front #(.TOP_SIZE(TOP_SIZE)) u_front (
    .clk, .rst, .push, .full, .func, .pc_value, .rank_select,
    .cmd_valid, .cmd, .cmd_pop
  );

  pshp_back #(.TABLE_DEPTH(TABLE_DEPTH), .TOP_SIZE(TOP_SIZE)) u_back (
    .clk, .rst, .cmd_valid, .cmd, .cmd_pop, .empty, .pop, .res
  );

  assign sample_status = res.status;
  assign rank_address  = res.addr;
  assign rank_count    = res.count;
  assign entries_used  = res.used;

endmodule
`default_nettype wire

[hw/rtl/pshp_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pshp_checker
// Port-level checks for the profiler, bound to the top level.
// ----------------------------------------------------------------------------
module pshp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [1:0]  sample_status,
  input wire logic [63:0] rank_address,
  input wire logic [31:0] rank_count,
  input wire logic [11:0] entries_used
);
  import pshp_pkg::*;

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> empty && !full)
    else $error("queues not empty after reset");

  a_sample_no_rank: assert property (@(posedge clk) disable iff (rst)
    !empty && sample_status != STS_NONE |-> rank_address == 64'd0 && rank_count == 32'd0)
    else $error("sample word carries rank data");

  a_new_nonzero: assert property (@(posedge clk) disable iff (rst)
    !empty && sample_status == STS_NEW |-> entries_used != 12'd0)
    else $error("new entry with empty table");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(sample_status) && $stable(rank_address)
      && $stable(rank_count) && $stable(entries_used))
    else $error("waiting word changed");

endmodule

bind pc_sample_hotspot_profiler_top pshp_checker u_chk (.*);
`default_nettype wire
